FILE: rtl/core/pyrirr_pkg.sv
// types and constants for the pyrgeometer irradiance correction
// no dependencies; used by pyrgeometer_irradiance_correct
package pyrirr_pkg;

  typedef struct packed {
    logic signed [23:0] raw_irradiance;
    logic signed [15:0] sink_temp;
    logic signed [15:0] dome_temp;
    logic        [31:0] dome_thermistor;
  } item_t;

  typedef struct packed {
    logic signed [23:0] irradiance;
    logic signed [15:0] dome_temp_out;
  } result_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_GAIN   = 2'd1,
    REG_OFFSET = 2'd2
  } reg_idx_e;

  localparam logic [16:0] KelvinQ8   = 17'd69926;
  localparam logic [19:0] SigmaQ44   = 20'd997231;
  localparam logic [16:0] E0Q17      = 17'd129237;
  localparam logic [47:0] DtBiasQ32  = 48'd113838088181;
  localparam logic [20:0] DtSlopeQ16 = 21'd1213034;

  // log2(1+i/2^bits) in q16 by repeated squaring on q30
  function automatic logic [16:0] log_entry(input int unsigned i, input int unsigned bits);
    logic [63:0] m;
    logic [16:0] r;
    m = (64'd1 << 30) + (64'(i) << (30 - bits));
    r = '0;
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 30;
      r = r << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        r = r | 17'd1;
      end
    end
    if (i == (32'd1 << bits)) begin
      r = 17'd65536;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/pyrgeometer_irradiance_correct.sv
// pyrgeometer irradiance correction, eight-stage pipeline
// depends on pyrirr_pkg
//
// One word is taken on every cycle that start is high (busy stays low) and
// its result leaves on result_o with done_o high after it has passed through
// the eight register stages of the log, kelvin and sigma*T^4 datapath. The
// receiver cannot stall, so results must be taken as they
// appear. Registers sit on the APB port at byte addresses 0 (mode), 4 (gain)
// and 8 (offset) and should only be written while no words are in flight.
module pyrgeometer_irradiance_correct #(
  parameter int unsigned LOG_TABLE_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  pyrirr_pkg::item_t   item_i,
  output logic                done_o,
  output pyrirr_pkg::result_t result_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import pyrirr_pkg::*;

  localparam int unsigned Tab = (1 << LOG_TABLE_BITS) + 1;
  localparam int unsigned Rb  = 31 - LOG_TABLE_BITS;

  // configuration
  logic               mode_q;
  logic signed [31:0] gain_q;
  logic signed [23:0] offset_q;
  logic               wr_en;
  reg_idx_e           reg_sel;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      gain_q   <= 32'sd65536;
      offset_q <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_MODE:   mode_q   <= pwdata[0];
        REG_GAIN:   gain_q   <= pwdata;
        REG_OFFSET: offset_q <= pwdata[23:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MODE:   prdata = {31'd0, mode_q};
      REG_GAIN:   prdata = gain_q;
      REG_OFFSET: prdata = 32'(offset_q);
      default:    prdata = '0;
    endcase
  end

  // log table
  logic [16:0] rom_w [Tab];
  for (genvar g = 0; g < Tab; g++) begin : g_rom
    localparam logic [16:0] Val = log_entry(g, LOG_TABLE_BITS);
    assign rom_w[g] = Val;
  end

  logic [8:1] v_q;

  // stage 1: capture
  logic               s1_mode_q;
  logic signed [23:0] s1_ir_q;
  logic signed [15:0] s1_ts_q, s1_td_q;
  logic [31:0]        s1_x_q;

  always_ff @(posedge clk_i) begin
    if (start) begin
      s1_mode_q <= mode_q;
      s1_ir_q   <= item_i.raw_irradiance;
      s1_ts_q   <= item_i.sink_temp;
      s1_td_q   <= item_i.dome_temp;
      s1_x_q    <= item_i.dome_thermistor;
    end
  end

  // stage 2: normalise, table read, gain product
  logic [31:0]               x2, fx2;
  logic [4:0]                e2;
  logic [LOG_TABLE_BITS-1:0] idx2;
  logic [LOG_TABLE_BITS:0]   idx2_lo, idx2_hi;
  logic [16:0]               r0_2, d2;
  logic signed [55:0]        prod2;

  always_comb begin
    x2 = (s1_x_q == '0) ? 32'd1 : s1_x_q;
    e2 = '0;
    for (int i = 0; i < 32; i++) begin
      if (x2[i]) e2 = 5'(i);
    end
    fx2     = x2 << (5'd31 - e2);
    idx2    = fx2[30 -: LOG_TABLE_BITS];
    idx2_lo = {1'b0, idx2};
    idx2_hi = idx2_lo + 1'b1;
    r0_2    = rom_w[idx2_lo];
    d2      = rom_w[idx2_hi] - rom_w[idx2_lo];
    prod2   = 56'(gain_q) * 56'(s1_ir_q);
  end

  logic               s2_mode_q;
  logic signed [23:0] s2_ir_q;
  logic signed [15:0] s2_ts_q, s2_td_q;
  logic [4:0]         s2_e_q;
  logic [16:0]        s2_r0_q, s2_d_q;
  logic [Rb-1:0]      s2_rem_q;
  logic signed [55:0] s2_prod_q;

  always_ff @(posedge clk_i) begin
    s2_mode_q <= s1_mode_q;
    s2_ir_q   <= s1_ir_q;
    s2_ts_q   <= s1_ts_q;
    s2_td_q   <= s1_td_q;
    s2_e_q    <= e2;
    s2_r0_q   <= r0_2;
    s2_d_q    <= d2;
    s2_rem_q  <= fx2[Rb-1:0];
    s2_prod_q <= prod2;
  end

  // stage 3: interpolate, round gain product
  logic [16+Rb:0]     ip3;
  logic [5:0]         es3;
  logic signed [21:0] l2_3;
  logic signed [55:0] qr3;

  always_comb begin
    ip3  = (17 + Rb)'(s2_d_q) * (17 + Rb)'(s2_rem_q);
    es3  = 6'(s2_e_q) - 6'd16;
    l2_3 = $signed({es3, 16'd0}) + $signed(22'(s2_r0_q)) + $signed(22'(ip3[16+Rb:Rb]));
    qr3  = (s2_prod_q + 56'sd32768) >>> 16;
  end

  logic               s3_mode_q;
  logic signed [23:0] s3_ir_q;
  logic signed [15:0] s3_ts_q, s3_td_q;
  logic signed [21:0] s3_l2_q;
  logic signed [39:0] s3_q_q;

  always_ff @(posedge clk_i) begin
    s3_mode_q <= s2_mode_q;
    s3_ir_q   <= s2_ir_q;
    s3_ts_q   <= s2_ts_q;
    s3_td_q   <= s2_td_q;
    s3_l2_q   <= l2_3;
    s3_q_q    <= qr3[39:0];
  end

  // stage 4: dome temperature from log, or the input dome temperature in mode 0
  logic signed [42:0] sp4;
  logic signed [47:0] tsum4, tsh4;
  logic signed [17:0] tdc4, tdome4;
  logic signed [15:0] dto4;

  always_comb begin
    sp4   = $signed({1'b0, DtSlopeQ16}) * s3_l2_q;
    tsum4 = $signed(DtBiasQ32) - 48'(sp4) + 48'sd8388608;
    tsh4  = tsum4 >>> 24;
    tdc4  = tsh4[17:0];
    if (s3_mode_q) begin
      tdome4 = tdc4;
      if (tdc4 > 18'sd32767)       dto4 = 16'sh7fff;
      else if (tdc4 < -18'sd32768) dto4 = 16'sh8000;
      else                         dto4 = tdc4[15:0];
    end else begin
      tdome4 = 18'(s3_td_q);
      dto4   = s3_td_q;
    end
  end

  logic               s4_mode_q;
  logic signed [23:0] s4_ir_q;
  logic signed [17:0] s4_tdome_q, s4_tsink_q;
  logic signed [15:0] s4_dto_q;
  logic signed [39:0] s4_q_q;

  always_ff @(posedge clk_i) begin
    s4_mode_q  <= s3_mode_q;
    s4_ir_q    <= s3_ir_q;
    s4_tdome_q <= tdome4;
    s4_tsink_q <= 18'(s3_ts_q);
    s4_dto_q   <= dto4;
    s4_q_q     <= s3_q_q;
  end

  // stage 5: kelvin and square
  logic signed [19:0] kd5, ks5;
  logic [17:0]        td5, ts5;
  logic [35:0]        sqd5, sqs5;

  always_comb begin
    kd5  = 20'(s4_tdome_q) + $signed({3'd0, KelvinQ8});
    ks5  = 20'(s4_tsink_q) + $signed({3'd0, KelvinQ8});
    td5  = kd5[19] ? '0 : kd5[17:0];
    ts5  = ks5[19] ? '0 : ks5[17:0];
    sqd5 = 36'(td5) * 36'(td5);
    sqs5 = 36'(ts5) * 36'(ts5);
  end

  logic               s5_mode_q;
  logic signed [23:0] s5_ir_q;
  logic signed [15:0] s5_dto_q;
  logic signed [39:0] s5_q_q;
  logic [24:0]        s5_ad_q, s5_as_q;

  always_ff @(posedge clk_i) begin
    s5_mode_q <= s4_mode_q;
    s5_ir_q   <= s4_ir_q;
    s5_dto_q  <= s4_dto_q;
    s5_q_q    <= s4_q_q;
    s5_ad_q   <= sqd5[34:10];
    s5_as_q   <= sqs5[34:10];
  end

  // stage 6: fourth power
  logic [49:0] qd6, qs6;

  assign qd6 = 50'(s5_ad_q) * 50'(s5_ad_q);
  assign qs6 = 50'(s5_as_q) * 50'(s5_as_q);

  logic               s6_mode_q;
  logic signed [23:0] s6_ir_q;
  logic signed [15:0] s6_dto_q;
  logic signed [39:0] s6_q_q;
  logic [33:0]        s6_bd_q, s6_bs_q;

  always_ff @(posedge clk_i) begin
    s6_mode_q <= s5_mode_q;
    s6_ir_q   <= s5_ir_q;
    s6_dto_q  <= s5_dto_q;
    s6_q_q    <= s5_q_q;
    s6_bd_q   <= qd6[49:16];
    s6_bs_q   <= qs6[49:16];
  end

  // stage 7: times sigma
  logic [53:0] pd7, ps7;

  assign pd7 = 54'(s6_bd_q) * 54'(SigmaQ44);
  assign ps7 = 54'(s6_bs_q) * 54'(SigmaQ44);

  logic               s7_mode_q;
  logic signed [23:0] s7_ir_q;
  logic signed [15:0] s7_dto_q;
  logic signed [39:0] s7_q_q;
  logic [29:0]        s7_sd_q, s7_ss_q;

  always_ff @(posedge clk_i) begin
    s7_mode_q <= s6_mode_q;
    s7_ir_q   <= s6_ir_q;
    s7_dto_q  <= s6_dto_q;
    s7_q_q    <= s6_q_q;
    s7_sd_q   <= pd7[53:30-6];
    s7_ss_q   <= ps7[53:30-6];
  end

  // stage 8: combine and saturate
  logic [46:0]        e0p8;
  logic signed [41:0] sum8, irr0_8, irr1_8, irr8;
  logic signed [23:0] irs8;

  always_comb begin
    e0p8   = 47'(s7_ss_q) * 47'(E0Q17);
    sum8   = (42'(s7_ir_q) <<< 9)
           - 42'sd11 * ($signed(42'(s7_sd_q)) - $signed(42'(s7_ss_q)))
           + $signed(42'(e0p8[46:16]));
    irr0_8 = (sum8 + 42'sd256) >>> 9;
    irr1_8 = 42'(s7_q_q) - 42'(offset_q) + $signed(42'((s7_sd_q + 30'd128) >> 8));
    irr8   = s7_mode_q ? irr1_8 : irr0_8;
    if (irr8 > 42'sd8388607)       irs8 = 24'sh7fffff;
    else if (irr8 < -42'sd8388608) irs8 = 24'sh800000;
    else                           irs8 = irr8[23:0];
  end

  result_t result_q;

  always_ff @(posedge clk_i) begin
    result_q.irradiance    <= irs8;
    result_q.dome_temp_out <= s7_dto_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[7:1], start};
    end
  end

  assign done_o   = v_q[8];
  assign result_o = result_q;

endmodule

FILE: tb/pyrgeometer_irradiance_correct_tb.sv
// testbench for pyrgeometer_irradiance_correct: irradiance and dome temperature
// checked against a bit-exact predictor; depends on pyrirr_pkg and the rtl
module pyrgeometer_irradiance_correct_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pyrirr_pkg::*;

  localparam int unsigned TabBits  = 8;
  localparam int          Latency  = 8;
  localparam int          Stall    = 2000;
  localparam longint      KelvinK  = 69926;
  localparam longint      SigmaK   = 997231;
  localparam longint      SinkEmis = 129237;
  localparam longint      LogBias  = 64'sd113838088181;
  localparam longint      LogSlope = 1213034;

  class irr_scoreboard;
    result_t     expected_q[$];
    bit          mode;
    longint      gain;
    longint      offset;
    longint      log2_tab[0:(1 << TabBits)];
    int          fails;
    int          checked;

    function new();
      bit [63:0] m;
      longint    r;
      for (int i = 0; i < (1 << TabBits); i++) begin
        m = (64'd1 << 30) + (64'(i) << (30 - TabBits));
        r = 0;
        for (int k = 0; k < 16; k++) begin
          m = (m * m) >> 30;
          r = r << 1;
          if (m >= (64'd2 << 30)) begin
            m = m >> 1;
            r = r | 1;
          end
        end
        log2_tab[i] = r;
      end
      log2_tab[1 << TabBits] = 65536;
      mode = 1'b0;
      gain = 65536;
      offset = 0;
    endfunction

    function longint sigma_t4(longint t);
      bit [63:0] u, a, b;
      if (t < 0) t = 0;
      u = t;
      a = (u * u) >> 10;
      b = (a * a) >> 16;
      return longint'((b * 64'(SigmaK)) >> 24);
    endfunction

    function longint log2_q16(bit [31:0] x);
      int        e;
      bit [63:0] f, rem, d;
      int        idx;
      e = 31;
      while (e > 0 && x[e] == 1'b0) e--;
      f = (64'(x) << (31 - e)) & 64'h7FFF_FFFF;
      idx = int'(f >> (31 - TabBits));
      rem = f & ((64'd1 << (31 - TabBits)) - 1);
      d = 64'(log2_tab[idx + 1] - log2_tab[idx]);
      return longint'(e - 16) * 65536 + log2_tab[idx] + longint'((d * rem) >> (31 - TabBits));
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void note_word(item_t it);
      longint  ir, ss, sd, sum, irr, dto, l2, tdc, s, q;
      bit [31:0] x;
      result_t res;
      ir = longint'(it.raw_irradiance);
      if (!mode) begin
        ss = sigma_t4(longint'(it.sink_temp) + KelvinK);
        sd = sigma_t4(longint'(it.dome_temp) + KelvinK);
        sum = ir * 512 - 11 * (sd - ss) + ((ss * SinkEmis) >>> 16);
        irr = (sum + 256) >>> 9;
        dto = longint'(it.dome_temp);
      end else begin
        x = it.dome_thermistor;
        // zero reading stands for the smallest positive value
        if (x == 0) x = 1;
        l2 = log2_q16(x);
        tdc = (LogBias - LogSlope * l2 + (64'sd1 <<< 23)) >>> 24;
        s = sigma_t4(tdc + KelvinK);
        q = (gain * ir + 32768) >>> 16;
        irr = q - offset + ((s + 128) >>> 8);
        dto = clip(tdc, -32768, 32767);
      end
      irr = clip(irr, -8388608, 8388607);
      res.irradiance = irr[23:0];
      res.dome_temp_out = dto[15:0];
      expected_q = {expected_q, res};
    endfunction

    function void check_word(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result word irradiance=%0d", got.irradiance);
        fails++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (got.irradiance !== exp_r.irradiance) begin
        $error("irradiance: expected %0d got %0d", exp_r.irradiance, got.irradiance);
        fails++;
      end
      if (got.dome_temp_out !== exp_r.dome_temp_out) begin
        $error("dome_temp_out: expected %0d got %0d", exp_r.dome_temp_out, got.dome_temp_out);
        fails++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  item_t       item_i = '0;
  logic        done_o;
  result_t     result_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  irr_scoreboard sb = new();
  int          sent;
  int          idle_cnt;
  int          mode1_words;

  always #5 clk_i = ~clk_i;

  pyrgeometer_irradiance_correct #(.LOG_TABLE_BITS(TabBits)) u_dut (
    .clk_i, .rst_ni, .start, .busy, .item_i, .done_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // accepted words and results, plus the stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        sb.note_word(item_i);
        if (sb.mode) mode1_words++;
      end
      if (done_o) sb.check_word(result_o);
      if ((start && !busy) || done_o) begin
        idle_cnt = 0;
      end else begin
        idle_cnt++;
        if (idle_cnt >= Stall) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_MODE:   sb.mode = val[0];
      REG_GAIN:   sb.gain = longint'($signed(val));
      REG_OFFSET: sb.offset = longint'($signed(val[23:0]));
      default: ;
    endcase
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic send_word(item_t it, bit gaps);
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    sent++;
    if (gaps && $urandom_range(0, 99) < 11) begin
      start <= 1'b0;
      item_i <= '0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic item_t rand_word();
    item_t it;
    it.raw_irradiance = 24'($urandom);
    if ($urandom_range(0, 1)) begin
      it.sink_temp = 16'($urandom);
      it.dome_temp = 16'($urandom);
    end else begin
      it.sink_temp = 16'(int'($urandom_range(0, 20480)) - 10240);
      it.dome_temp = 16'(int'($urandom_range(0, 20480)) - 10240);
    end
    case ($urandom_range(0, 3))
      0: it.dome_thermistor = $urandom;
      1: it.dome_thermistor = $urandom_range(1, 1 << 20);
      2: it.dome_thermistor = (32'd1 << $urandom_range(0, 31)) | $urandom_range(0, 255);
      default: it.dome_thermistor = 32'($urandom_range(0, 4)) << 16 | 16'($urandom);
    endcase
    return it;
  endfunction

  task automatic directed_words();
    item_t it;
    for (int i = 0; i < 10; i++) begin
      it = '0;
      case (i)
        0: it.raw_irradiance = 24'h7FFFFF;
        1: it.raw_irradiance = 24'h800000;
        2: begin it.sink_temp = 16'h7FFF; it.dome_temp = 16'h8000; end
        3: begin it.sink_temp = 16'h8000; it.dome_temp = 16'h7FFF; end
        4: begin it.raw_irradiance = 24'h7FFFFF; it.dome_temp = 16'h8000; end
        5: it.dome_thermistor = 32'd0;
        6: it.dome_thermistor = 32'd1;
        7: it.dome_thermistor = 32'hFFFF_FFFF;
        8: begin it.dome_thermistor = 32'h0001_0000; it.raw_irradiance = 24'h800000; end
        default: begin it.dome_thermistor = 32'h0000_8000; it.raw_irradiance = 24'h7FFFFF; end
      endcase
      send_word(it, 1'b0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: ;
        1: write_reg(REG_MODE, 32'd1);
        2: begin write_reg(REG_GAIN, 32'h7FFF_FFFF); write_reg(REG_OFFSET, 32'h007F_FFFF); end
        3: begin write_reg(REG_GAIN, 32'h8000_0000); write_reg(REG_OFFSET, 32'hFF80_0000); end
        4: begin
          write_reg(REG_GAIN, 32'($urandom_range(0, 1 << 18)) - 32'h0002_0000);
          write_reg(REG_OFFSET, $urandom);
        end
        5: begin write_reg(REG_GAIN, 32'h0001_0000); write_reg(REG_OFFSET, 32'd0); end
        default: write_reg(REG_MODE, 32'd0);
      endcase
      if (ph < 2) directed_words();
      for (int n = 0; n < 75; n++) begin
        // one stretch with no gaps at all
        send_word(rand_word(), ph != 3);
      end
      start <= 1'b0;
      item_i <= '0;
      drain();
    end
    $display("%0d words sent, %0d results checked, %0d of them in thermistor mode",
             sent, sb.checked, mode1_words);
    $display("gain and offset covered at both extremes, reset values and random settings");
    if (sb.fails == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
